// ===== rtl/core/stat_pkg.sv =====
// Package for the section table address translator.
// Holds field widths, status, operation and register codes, the FSM state type
// and the section entry layout. Depends on nothing.
package stat_pkg;

	localparam int MAX_SECTIONS_DEF = 16;
	localparam int ADDR_W           = 32;
	localparam int IMAGE_W          = 29;
	localparam int COUNT_W          = 5;
	localparam int SLOT_W           = 4;
	localparam int STATUS_W         = 3;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 29;

	typedef enum logic [0:0] {
		OP_WRITE     = 1'b0,
		OP_TRANSLATE = 1'b1
	} stat_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK              = 3'd0,
		STS_ZERO            = 3'd1,
		STS_PAST_IMAGE      = 3'd2,
		STS_NO_SECTION      = 3'd3,
		STS_PAST_RAW        = 3'd4,
		STS_FILE_PAST_IMAGE = 3'd5
	} stat_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOADED_MODE   = 2'd0,
		CFG_IMAGE_SIZE    = 2'd1,
		CFG_SECTION_COUNT = 2'd2
	} stat_cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_DONE
	} stat_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] virt_start;
		logic [ADDR_W-1:0] virt_size;
		logic [ADDR_W-1:0] raw_start;
		logic [ADDR_W-1:0] raw_len;
	} stat_entry_t;

endpackage

// ===== rtl/core/stat_cfg_if.sv =====
// Configuration write channel of the address translator.
// Depends on stat_pkg for the index and data widths.
interface stat_cfg_if;
	import stat_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/stat_in_if.sv =====
// Command channel of the address translator: section writes and translate requests.
// Depends on stat_pkg for the field widths.
interface stat_in_if;
	import stat_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [SLOT_W-1:0] entry_index;
	logic [ADDR_W-1:0] new_virt_start;
	logic [ADDR_W-1:0] new_virt_size;
	logic [ADDR_W-1:0] new_raw_start;
	logic [ADDR_W-1:0] new_raw_len;
	logic [ADDR_W-1:0] rva;

	modport source (
		output valid, output operation, output entry_index, output new_virt_start,
		output new_virt_size, output new_raw_start, output new_raw_len, output rva,
		input ready
	);
	modport sink (
		input valid, input operation, input entry_index, input new_virt_start,
		input new_virt_size, input new_raw_start, input new_raw_len, input rva,
		output ready
	);
endinterface

// ===== rtl/core/stat_out_if.sv =====
// Result channel of the address translator.
// Depends on stat_pkg for the field widths.
interface stat_out_if;
	import stat_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   trans_offset;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   matched_section;

	modport source (
		output valid, output trans_offset, output status, output matched_section,
		input ready
	);
	modport sink (
		input valid, input trans_offset, input status, input matched_section,
		output ready
	);
endinterface

// ===== rtl/core/stat_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependency.
module stat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/section_table_address_translator_core.sv =====
// Sequence: a write, zero-address or loaded-mode beat goes from IDLE to DONE and then to the
// output register; a file-mode beat reads the slots in SCAN one after another through the
// single read port of the section RAM, passes through CHECK on a hit, then DONE. One beat at
// a time in the sequencer; a new beat is taken only in IDLE.
// Reset: arst_n clears the FSM, the configuration registers (all zero) and the result
// valid; the section RAM is not cleared and an entry reads as undefined until written.
module section_table_address_translator_core #(
	parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	stat_cfg_if.sink    cfg,
	stat_in_if.sink     cmd,
	stat_out_if.source  resp
);
	import stat_pkg::*;

	// Table address width and a counter width that can also hold the slot count itself.
	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);

	// Configuration registers.
	logic               loaded_mode_q;
	logic [IMAGE_W-1:0] image_size_q;
	logic [COUNT_W-1:0] section_count_q;

	// Sequencer.
	stat_state_t state_q, state_d;

	// Scan pointers: rd_idx_q is the slot being read this cycle, lag_idx_q the slot whose
	// data sits on the registered RAM output, trailing the read pointer.
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] lag_idx_q;
	logic [CW-1:0] hit_idx_q;
	logic [CW-1:0] limit;

	// Beat payload held while the scan runs.
	logic [ADDR_W-1:0] rva_q;
	logic [ADDR_W-1:0] delta_q;
	logic [ADDR_W-1:0] raw_start_q;
	logic [ADDR_W-1:0] raw_len_q;

	// Pending result, waiting for the output register.
	logic [ADDR_W-1:0] res_off_q;
	stat_status_t      res_sts_q;
	logic [SLOT_W-1:0] res_idx_q;

	// Output register.
	logic              resp_valid_q;
	logic [ADDR_W-1:0] resp_off_q;
	stat_status_t      resp_sts_q;
	logic [SLOT_W-1:0] resp_idx_q;

	// Section RAM ports.
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	stat_entry_t ram_wdata;
	logic        ram_re;
	logic [AW-1:0] ram_raddr;
	stat_entry_t rd_entry;

	// Datapath terms.
	logic              cmd_fire;
	logic              is_write;
	logic              slot_ok;
	logic              needs_scan;
	logic [ADDR_W-1:0] virt_end;
	logic              hit;
	logic              scan_last;
	logic [ADDR_W-1:0] file_off;
	logic              out_free;

	// ------------------------------------------------------------------
	// Section table: one 128-bit entry per slot. Writes happen only at accept
	// in IDLE and reads only during the scan, so a read never meets a write
	// to the same entry in flight; no forwarding is needed.
	// ------------------------------------------------------------------
	stat_ram #(
		.WIDTH ($bits(stat_entry_t)),
		.DEPTH (MAX_SECTIONS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// ------------------------------------------------------------------
	// Configuration port: always ready; indexes past the list are dropped.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_mode_q   <= 1'b0;
			image_size_q    <= '0;
			section_count_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LOADED_MODE:   loaded_mode_q   <= cfg.data[0];
				CFG_IMAGE_SIZE:    image_size_q    <= cfg.data[IMAGE_W-1:0];
				CFG_SECTION_COUNT: section_count_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Decode of the incoming beat and the scan compare.
	// ------------------------------------------------------------------
	// Clamp the scan to the table depth.
	assign limit = (32'(section_count_q) > 32'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS)
	                                                          : CW'(section_count_q);

	assign cmd_fire   = cmd.valid && cmd.ready;
	assign is_write   = (stat_op_t'(cmd.operation) == OP_WRITE);
	assign slot_ok    = (32'(cmd.entry_index) < 32'(MAX_SECTIONS));
	assign needs_scan = !is_write && (cmd.rva != '0) && !loaded_mode_q && (limit != '0);

	// Virtual range end wraps at 32 bits, as the address arithmetic does.
	assign virt_end  = rd_entry.virt_start + rd_entry.virt_size;
	assign hit       = (rva_q >= rd_entry.virt_start) && (rva_q < virt_end);
	assign scan_last = (({1'b0, lag_idx_q} + (CW+1)'(1)) == {1'b0, limit});

	assign file_off = raw_start_q + delta_q;
	assign out_free = !resp_valid_q || resp.ready;

	assign ram_wdata = '{
		virt_start: cmd.new_virt_start,
		virt_size:  cmd.new_virt_size,
		raw_start:  cmd.new_raw_start,
		raw_len:    cmd.new_raw_len
	};
	assign ram_waddr = AW'(cmd.entry_index);

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					state_d = needs_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_CHECK;
				end else if (scan_last) begin
					state_d = S_DONE;
				end
			end
			S_CHECK: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs. Take a beat only in IDLE; the output register
	// in front lets a new beat in while the last result still waits.
	// ------------------------------------------------------------------
	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				// Ready is high throughout IDLE, so a valid beat is an accepted one.
				cmd.ready = 1'b1;
				ram_we    = cmd.valid && is_write && slot_ok;
				// Start the scan read of slot 0 in the accept cycle.
				ram_re    = cmd.valid && needs_scan;
			end
			S_SCAN: begin
				ram_raddr = AW'(rd_idx_q);
				ram_re    = (rd_idx_q < limit);
			end
			S_CHECK, S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_idx_q  <= '0;
			lag_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				if (cmd_fire) begin
					rd_idx_q  <= CW'(1);
					lag_idx_q <= '0;
				end
			end else if (state_q == S_SCAN) begin
				// Advance the read pointer until it reaches the clamped count.
				if (rd_idx_q < limit) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				lag_idx_q <= rd_idx_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Beat payload and pending result.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					rva_q     <= cmd.rva;
					res_off_q <= '0;
					res_idx_q <= '0;
					res_sts_q <= STS_OK;
					if (!is_write) begin
						if (cmd.rva == '0) begin
							res_sts_q <= STS_ZERO;
						end else if (loaded_mode_q) begin
							// Loaded layout: the address is the offset, bounded by the image.
							if (cmd.rva >= ADDR_W'(image_size_q)) begin
								res_sts_q <= STS_PAST_IMAGE;
							end else begin
								res_off_q <= cmd.rva;
							end
						end else begin
							// Preset a miss; a hit in the scan overrides it.
							res_sts_q <= STS_NO_SECTION;
						end
					end
				end
			end
			S_SCAN: begin
				// Latch the first matching entry and the offset into its range.
				if (hit) begin
					delta_q     <= rva_q - rd_entry.virt_start;
					raw_start_q <= rd_entry.raw_start;
					raw_len_q   <= rd_entry.raw_len;
					hit_idx_q   <= lag_idx_q;
				end
			end
			S_CHECK: begin
				res_idx_q <= SLOT_W'(hit_idx_q);
				if (delta_q >= raw_len_q) begin
					res_sts_q <= STS_PAST_RAW;
				end else if (file_off >= ADDR_W'(image_size_q)) begin
					res_sts_q <= STS_FILE_PAST_IMAGE;
				end else begin
					res_sts_q <= STS_OK;
					res_off_q <= file_off;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: load from the pending result in DONE, hold while stalled.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			resp_valid_q <= 1'b1;
		end else if (resp.ready) begin
			resp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			resp_off_q <= res_off_q;
			resp_sts_q <= res_sts_q;
			resp_idx_q <= res_idx_q;
		end
	end

	assign resp.valid           = resp_valid_q;
	assign resp.trans_offset    = resp_off_q;
	assign resp.status          = resp_sts_q;
	assign resp.matched_section = resp_idx_q;

endmodule

// ===== sim/section_table_address_translator_core_tb.sv =====
// Self-checking testbench for section_table_address_translator_core.
// Drives section writes, translate requests and register writes through the
// stat_* interfaces; depends on stat_pkg and the three channel interfaces.
module section_table_address_translator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stat_pkg::*;

	localparam int          SLOTS     = MAX_SECTIONS_DEF;
	localparam int unsigned RUN_LIMIT = 500000;
	// Index past the register list; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	// One command beat as seen on the input channel.
	typedef struct {
		stat_op_t          op;
		logic [SLOT_W-1:0] slot;
		stat_entry_t       entry;
		logic [ADDR_W-1:0] rva;
	} sect_cmd_t;

	// One translation outcome as seen on the result channel.
	typedef struct {
		logic [ADDR_W-1:0] offset;
		stat_status_t      status;
		logic [SLOT_W-1:0] section;
	} xlate_result_t;

	// Mirror of the section table and registers; computes each translation
	// as a command beat is accepted and holds it until its result beat shows.
	class section_table_mirror;
		stat_entry_t        sections [SLOTS];
		bit                 loaded_mode;
		logic [ADDR_W-1:0]  image_size;
		logic [COUNT_W-1:0] section_count;
		xlate_result_t      due_translations [$];
		int unsigned        errors;

		function new();
			loaded_mode   = 1'b0;
			image_size    = '0;
			section_count = '0;
			errors        = 0;
		endfunction

		function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LOADED_MODE:   loaded_mode = data[0];
				CFG_IMAGE_SIZE:    image_size = {3'b000, data[IMAGE_W-1:0]};
				CFG_SECTION_COUNT: section_count = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_command(sect_cmd_t beat);
			xlate_result_t     r;
			logic [ADDR_W-1:0] vend;
			logic [ADDR_W-1:0] delta;
			logic [ADDR_W-1:0] foff;
			int unsigned       span;
			bit                found;
			r.offset  = '0;
			r.status  = STS_OK;
			r.section = '0;
			found     = 1'b0;
			if (beat.op == OP_WRITE) begin
				// A 4-bit slot always lands inside a 16-entry table.
				sections[beat.slot] = beat.entry;
			end else if (beat.rva == '0) begin
				r.status = STS_ZERO;
			end else if (loaded_mode) begin
				if (beat.rva >= image_size) r.status = STS_PAST_IMAGE;
				else r.offset = beat.rva;
			end else begin
				span     = (section_count > SLOTS) ? SLOTS : section_count;
				r.status = STS_NO_SECTION;
				for (int i = 0; i < span && !found; i++) begin
					vend = sections[i].virt_start + sections[i].virt_size;
					if (beat.rva >= sections[i].virt_start && beat.rva < vend) begin
						found     = 1'b1;
						delta     = beat.rva - sections[i].virt_start;
						foff      = sections[i].raw_start + delta;
						r.section = SLOT_W'(i);
						if (delta >= sections[i].raw_len) begin
							r.status = STS_PAST_RAW;
						end else if (foff >= image_size) begin
							r.status = STS_FILE_PAST_IMAGE;
						end else begin
							r.status = STS_OK;
							r.offset = foff;
						end
					end
				end
			end
			due_translations.insert(due_translations.size(), r);
		endfunction

		function void flag_field(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
		endfunction

		function void match_result(xlate_result_t got);
			xlate_result_t want;
			if (due_translations.size() == 0) begin
				errors++;
				$display("%0t: result beat with none pending: expected nothing, actual %h/%0d/%0d",
					$time, got.offset, got.status, got.section);
				return;
			end
			want = due_translations.pop_front();
			if (got.offset !== want.offset) flag_field("trans_offset", want.offset, got.offset);
			if (got.status !== want.status) flag_field("status", want.status, got.status);
			if (got.section !== want.section)
				flag_field("matched_section", want.section, got.section);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stat_cfg_if cfg_bus ();
	stat_in_if  cmd_bus ();
	stat_out_if res_bus ();

	section_table_address_translator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.resp   (res_bus)
	);

	section_table_mirror mirror;

	// Stimulus-side copy of the table and registers, used to aim addresses
	// at real sections; the checker keeps its own copy.
	stat_entry_t        layout_mirror [SLOTS];
	bit                 cur_loaded;
	logic [ADDR_W-1:0]  cur_image;
	logic [COUNT_W-1:0] cur_count;

	// Idle control shared by both sides: quiet drops all random gaps,
	// hold_off_req asks the result side for one long stall.
	bit          quiet        = 1'b0;
	int unsigned hold_off_req = 0;
	int unsigned cycles       = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("section_table_address_translator_core_tb NOT OK");
			$finish;
		end
	end

	// Watch all three channels; every accepted beat feeds the mirror.
	always @(posedge clk) begin
		sect_cmd_t     seen;
		xlate_result_t got;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) mirror.apply_cfg(cfg_bus.index, cfg_bus.data);
			if (cmd_bus.valid && cmd_bus.ready) begin
				seen.op               = stat_op_t'(cmd_bus.operation);
				seen.slot             = cmd_bus.entry_index;
				seen.entry.virt_start = cmd_bus.new_virt_start;
				seen.entry.virt_size  = cmd_bus.new_virt_size;
				seen.entry.raw_start  = cmd_bus.new_raw_start;
				seen.entry.raw_len    = cmd_bus.new_raw_len;
				seen.rva              = cmd_bus.rva;
				mirror.take_command(seen);
			end
			if (res_bus.valid && res_bus.ready) begin
				got.offset  = res_bus.trans_offset;
				got.status  = stat_status_t'(res_bus.status);
				got.section = res_bus.matched_section;
				mirror.match_result(got);
			end
		end
	end

	// Result side: draw a stall per beat, then hold ready until a beat moves.
	// A pending hold-off request replaces one draw with a long stall so the
	// block fills and backs up its command channel.
	initial begin : result_sink
		int unsigned stall;
		res_bus.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_off_req != 0) begin
				stall        = hold_off_req;
				hold_off_req = 0;
			end else if (quiet) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 8);
			end
			if (stall != 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
		end
	end

	// Present one register beat and wait for it to move; the caller drops valid.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
	endtask

	// Write all three registers in a rotating order, after an optional write to the
	// spare index. Unused upper data bits carry noise, which the block must drop.
	task automatic configure(bit loaded, logic [IMAGE_W-1:0] image, logic [COUNT_W-1:0] count,
			bit poke);
		stat_cfg_reg_t which;
		int unsigned   start;
		start = $urandom_range(0, 2);
		if (poke) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
		for (int n = 0; n < 3; n++) begin
			which = stat_cfg_reg_t'((start + n) % 3);
			case (which)
				CFG_LOADED_MODE: write_reg(which, {28'($urandom), loaded});
				CFG_IMAGE_SIZE:  write_reg(which, image);
				default:         write_reg(which, {24'($urandom), count});
			endcase
		end
		cfg_bus.valid <= 1'b0;
		cur_loaded = loaded;
		cur_image  = {3'b000, image};
		cur_count  = count;
	endtask

	// Present one command beat after a random gap (none when quiet); valid stays high on return.
	task automatic send_cmd(sect_cmd_t c);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid          <= 1'b1;
		cmd_bus.operation      <= c.op;
		cmd_bus.entry_index    <= c.slot;
		cmd_bus.new_virt_start <= c.entry.virt_start;
		cmd_bus.new_virt_size  <= c.entry.virt_size;
		cmd_bus.new_raw_start  <= c.entry.raw_start;
		cmd_bus.new_raw_len    <= c.entry.raw_len;
		cmd_bus.rva            <= c.rva;
		if (c.op == OP_WRITE) layout_mirror[c.slot] = c.entry;
		do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
	endtask

	// Fully random beat; callers override the fields that matter.
	function automatic sect_cmd_t noise_beat();
		sect_cmd_t c;
		c.op               = stat_op_t'($urandom_range(0, 1));
		c.slot             = SLOT_W'($urandom);
		c.entry.virt_start = $urandom;
		c.entry.virt_size  = $urandom;
		c.entry.raw_start  = $urandom;
		c.entry.raw_len    = $urandom;
		c.rva              = $urandom;
		return c;
	endfunction

	task automatic send_write(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] vs,
			logic [ADDR_W-1:0] vsz, logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] rsz);
		sect_cmd_t c;
		c       = noise_beat();
		c.op    = OP_WRITE;
		c.slot  = slot;
		c.entry = '{vs, vsz, rs, rsz};
		send_cmd(c);
	endtask

	task automatic send_xlate(logic [ADDR_W-1:0] rva);
		sect_cmd_t c;
		c    = noise_beat();
		c.op = OP_TRANSLATE;
		c.rva = rva;
		send_cmd(c);
	endtask

	// Plausible section: slots spaced 64 KiB apart, sizes that sometimes
	// spill into the next slot, raw size around the virtual size, and now and
	// then a raw start near the image end.
	function automatic stat_entry_t tidy_section(logic [SLOT_W-1:0] slot);
		stat_entry_t e;
		e.virt_start = 32'h1000 + (32'(slot) << 16) + $urandom_range(0, 32'hFFF);
		e.virt_size  = $urandom_range(1, 32'h18000);
		if ($urandom_range(0, 9) == 0) e.raw_start = cur_image - $urandom_range(0, 32'h800);
		else e.raw_start = $urandom_range(0, 32'h0010_0000);
		e.raw_len = e.virt_size + $urandom_range(0, 32'h1000) - 32'h800;
		return e;
	endfunction

	// Mostly translates aimed at live sections and their edges, plus section
	// rewrites, the odd wild entry, zero and fully random addresses.
	task automatic send_random_item();
		sect_cmd_t         c;
		int unsigned       pick;
		int unsigned       sel;
		int unsigned       span;
		int unsigned       j;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		c    = noise_beat();
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			c.op = OP_WRITE;
			if (pick >= 2) c.entry = tidy_section(c.slot);
		end else begin
			c.op = OP_TRANSLATE;
			sel  = $urandom_range(0, 99);
			span = (cur_count > SLOTS) ? SLOTS : cur_count;
			if (sel < 5) begin
				c.rva = '0;
			end else if (sel >= 20) begin
				if (cur_loaded) begin
					if (sel < 40) c.rva = cur_image - 1 + $urandom_range(0, 2);
					else c.rva = $urandom_range(1, cur_image + 16);
				end else if (span == 0) begin
					c.rva = $urandom_range(1, 32'h0010_0000);
				end else begin
					j    = $urandom_range(0, span - 1);
					base = layout_mirror[j].virt_start;
					size = layout_mirror[j].virt_size;
					// Hit the last byte or one past the end, the byte before
					// the start, or anywhere inside.
					if (sel < 35) c.rva = base + size - $urandom_range(0, 1);
					else if (sel < 42) c.rva = base - 1;
					else c.rva = base + ((size == 0) ? 0 : $urandom % size);
				end
			end
		end
		send_cmd(c);
	endtask

	// Drop valid and wait until every pending translation has come back,
	// then give the block time to go idle.
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (mirror.due_translations.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(bit loaded, logic [IMAGE_W-1:0] image, logic [COUNT_W-1:0] count,
			bit calm, bit squeeze, int unsigned beats, bit refill);
		sect_cmd_t c;
		settle();
		quiet = calm;
		configure(loaded, image, count, 1'($urandom_range(0, 1)));
		// Load every slot before any scan can reach it.
		if (refill) begin
			for (int s = 0; s < SLOTS; s++) begin
				c       = noise_beat();
				c.op    = OP_WRITE;
				c.slot  = SLOT_W'(s);
				c.entry = tidy_section(SLOT_W'(s));
				send_cmd(c);
			end
		end
		for (int n = 0; n < beats; n++) begin
			if (squeeze && n == beats / 3) hold_off_req = 150;
			send_random_item();
		end
	endtask

	initial begin
		mirror = new();
		arst_n                 <= 1'b0;
		cfg_bus.valid          <= 1'b0;
		cfg_bus.index          <= '0;
		cfg_bus.data           <= '0;
		cmd_bus.valid          <= 1'b0;
		cmd_bus.operation      <= OP_WRITE;
		cmd_bus.entry_index    <= '0;
		cmd_bus.new_virt_start <= '0;
		cmd_bus.new_virt_size  <= '0;
		cmd_bus.new_raw_start  <= '0;
		cmd_bus.new_raw_len    <= '0;
		cmd_bus.rva            <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Loaded layout: zero address, last byte, image end, all ones.
		configure(1'b1, 29'h1000, 5'd0, 1'b0);
		send_xlate(32'h0);
		send_xlate(32'h0000_0FFF);
		send_xlate(32'h0000_1000);
		send_xlate(32'hFFFF_FFFF);
		// Load slots while loaded: overlapping pair, a range whose end
		// wraps below its start, a raw start that wraps the file offset.
		send_write(4'd0, 32'h0000_1000, 32'h0000_1000, 32'h0000_0400, 32'h0000_0800);
		send_write(4'd1, 32'h0000_1000, 32'h0000_4000, 32'h0000_2000, 32'h0000_4000);
		send_write(4'd2, 32'hFFFF_F000, 32'h0000_2000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_write(4'd3, 32'h8000_0000, 32'h0000_1000, 32'hFFFF_FF00, 32'h0000_1000);
		send_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Table walk over four slots with the largest image.
		settle();
		configure(1'b0, 29'h1FFF_FFFF, 5'd4, 1'b1);
		send_xlate(32'h0);
		send_xlate(32'h0000_1000);
		send_xlate(32'h0000_17FF);
		send_xlate(32'h0000_1800);
		send_xlate(32'h0000_2000);
		send_xlate(32'h0000_4FFF);
		send_xlate(32'h0000_5000);
		send_xlate(32'hFFFF_F800);
		send_xlate(32'h8000_0100);
		send_xlate(32'h8000_0000);

		// Empty image in both modes.
		settle();
		configure(1'b0, 29'h0, 5'd4, 1'b0);
		send_xlate(32'h0000_1000);
		settle();
		configure(1'b1, 29'h0, 5'd4, 1'b0);
		send_xlate(32'h0000_0001);

		//        mode  image                          count                      calm sq  beats fill
		run_phase(1'b0, 29'h1FFF_FFFF,                 5'd16,                     1'b0, 1'b1, 150, 1'b1);
		run_phase(1'b0, 29'($urandom_range(32'h10_0000, 32'h40_0000)),
			5'($urandom_range(1, 15)), 1'b1, 1'b0, 130, 1'b0);
		run_phase(1'b0, 29'h0008_0000,                 5'd31,                     1'b0, 1'b0, 130, 1'b0);
		run_phase(1'b1, 29'h1FFF_FFFF,                 5'd0,                      1'b0, 1'b0, 110, 1'b0);
		run_phase(1'b1, 29'h0,                         5'd5,                      1'b0, 1'b0,  50, 1'b0);
		run_phase(1'b0, 29'h0,                         5'd16,                     1'b0, 1'b0,  70, 1'b0);
		run_phase(1'b0, 29'($urandom),                 5'd1,                      1'b0, 1'b1, 110, 1'b0);
		run_phase(1'b0, 29'h1FFF_FFFF,                 5'($urandom_range(17, 30)), 1'b1, 1'b0, 100, 1'b0);
		run_phase(1'b1, 29'($urandom),                 5'($urandom),              1'b0, 1'b1, 110, 1'b0);
		run_phase(1'b0, 29'h1FFF_FFFF,                 5'd0,                      1'b0, 1'b0,  60, 1'b0);

		// Drain, then leave room for any stray result beat to show up.
		settle();
		repeat (24) @(posedge clk);
		if (mirror.errors == 0)
			$display("section_table_address_translator_core_tb OK");
		else
			$display("section_table_address_translator_core_tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/stat_pkg.sv
rtl/core/stat_cfg_if.sv
rtl/core/stat_in_if.sv
rtl/core/stat_out_if.sv
rtl/core/stat_ram.sv
rtl/core/section_table_address_translator_core.sv
sim/section_table_address_translator_core_tb.sv
